/* design/appr_pkg.sv */
package appr_pkg;

    // ARP operation handled by the proxy
    localparam logic [15:0] OP_REQUEST = 16'd1;

    // Input item kinds (carried on s_tuser)
    localparam logic [1:0] REQ_ARP       = 2'd0;
    localparam logic [1:0] REQ_FOUND     = 2'd1;
    localparam logic [1:0] REQ_NOT_FOUND = 2'd2;

    // Result kinds (carried on m_tuser)
    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_IP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_MAC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_PREFIX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK   = 2'd3;

    // Most replies a single found answer may release
    localparam int MAX_RESULTS = 16;
    localparam int SRV_W       = $clog2(MAX_RESULTS + 1);

    // One pending-table entry as held in memory
    typedef struct packed {
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } pend_entry_t;

    // One result beat, without the tlast flag
    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [47:0] dst_mac;
        logic [31:0] dst_ip;
        logic [31:0] lookup_ip;
    } result_t;

endpackage

/* design/arp_proxy_pending_resolver_unit.sv */
// ARP proxy with a pending-request table.
//
// Input beats arrive on s_tvalid/s_tready: s_tuser gives the kind (ARP packet,
// lookup found, lookup not found), s_tdata the packet and answer fields.
// Results leave on m_tvalid/m_tready: m_tuser gives the kind (reply, lookup
// request, drop), m_tdata the fields, m_tlast marks the last beat of an item.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, the block itself does not enforce this.
//
// A proxied request (router IP or off-subnet target) puts its reply in the
// hold register; ST_FLUSH moves it to the output register once that is free.
// Other ARP requests and found or not-found answers sweep the pending table
// held in a single-port-read RAM, one entry per cycle unless the receiver
// stalls; other ARP operations and unknown kinds give no result. A new beat
// is accepted once the previous item's last result sits in the output
// register.
//
// Reset clears all valid bits and the control and configuration registers; the
// table RAM needs no clear. When the receiver stalls, the sweep holds on the
// next matching entry and resumes as soon as the output register drains; no result is lost.
module arp_proxy_pending_resolver_unit #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic [appr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]                    cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] op_code, [63:16] sender_mac, [95:64] sender_ip,
    // [127:96] target_ip, [175:128] resolved_mac
    input  logic [175:0]                   s_tdata,
    // [1:0] req_type
    input  logic [1:0]                     s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [47:0] reply_src_mac, [79:48] reply_src_ip, [127:80] reply_dst_mac,
    // [159:128] reply_dst_ip, [191:160] lookup_ip
    output logic [191:0]                   m_tdata,
    // [1:0] out_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);

    import appr_pkg::*;

    localparam int IDX_W   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
    localparam int ENTRY_W = $bits(pend_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_FLUSH
    } state_t;

    // control state
    state_t                   state_reg, state_next;
    logic [PENDING_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         rd_addr_reg, rd_addr_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic                     out_valid_reg, out_valid_next;

    // configuration
    logic [31:0] router_ip_reg;
    logic [47:0] router_mac_reg;
    logic [31:0] subnet_prefix_reg;
    logic [31:0] subnet_mask_reg;

    // item and sweep payload
    logic [1:0]       type_reg, type_next;
    logic [47:0]      smac_reg, smac_next;
    logic [31:0]      sip_reg, sip_next;
    logic [31:0]      tip_reg, tip_next;
    logic [47:0]      rmac_reg, rmac_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             similar_reg, similar_next;
    logic             dup_reg, dup_next;
    logic [SRV_W-1:0] served_reg, served_next;
    result_t          hold_reg, hold_next;
    result_t          out_reg, out_next;
    logic             out_last_reg, out_last_next;

    // RAM port signals
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    pend_entry_t      ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    pend_entry_t      entry;

    // decoded input beat
    logic [15:0] in_op;
    logic [47:0] in_smac;
    logic [31:0] in_sip;
    logic [31:0] in_tip;
    logic [47:0] in_rmac;
    logic        proxy_hit;

    logic             out_free;
    logic             hit;
    logic             take;
    logic             stall;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;

    appr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign entry = pend_entry_t'(ram_rd_data);

    // unpack the input beat
    assign in_op   = s_tdata[15:0];
    assign in_smac = s_tdata[63:16];
    assign in_sip  = s_tdata[95:64];
    assign in_tip  = s_tdata[127:96];
    assign in_rmac = s_tdata[175:128];

    // answer directly for the router itself or an off-subnet target
    assign proxy_hit = (in_tip == router_ip_reg) ||
                       ((subnet_mask_reg != 32'd0) &&
                        (((in_tip ^ subnet_prefix_reg) & subnet_mask_reg) != 32'd0));

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // compare the entry returned by the RAM
    assign hit   = rd_pend_reg && valid_reg[rd_idx_reg] && (entry.target_ip == tip_reg);
    assign take  = hit && (type_reg == REQ_FOUND) && (served_reg < SRV_W'(MAX_RESULTS));
    assign stall = take && hold_valid_reg && !out_free;

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_addr_next    = rd_addr_reg;
        rd_pend_next    = rd_pend_reg;
        hold_valid_next = hold_valid_reg;
        type_next       = type_reg;
        smac_next       = smac_reg;
        sip_next        = sip_reg;
        tip_next        = tip_reg;
        rmac_next       = rmac_reg;
        rd_idx_next     = rd_idx_reg;
        similar_next    = similar_reg;
        dup_next        = dup_reg;
        served_next     = served_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = free_idx;
        ram_wr_data     = '{sender_mac: smac_reg, sender_ip: sip_reg, target_ip: tip_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = rd_addr_reg[IDX_W-1:0];

        // drain the output register
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    type_next    = s_tuser;
                    smac_next    = in_smac;
                    sip_next     = in_sip;
                    tip_next     = in_tip;
                    rmac_next    = in_rmac;
                    rd_addr_next = '0;
                    rd_pend_next = 1'b0;
                    similar_next = 1'b0;
                    dup_next     = 1'b0;
                    served_next  = '0;
                    if (s_tuser == REQ_ARP)
                    begin
                        if (in_op == OP_REQUEST)
                        begin
                            if (proxy_hit)
                            begin
                                hold_next       = '{kind: KIND_REPLY, src_mac: router_mac_reg,
                                                    src_ip: in_tip, dst_mac: in_smac,
                                                    dst_ip: in_sip, lookup_ip: 32'd0};
                                hold_valid_next = 1'b1;
                                state_next      = ST_FLUSH;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    else if (s_tuser == REQ_FOUND || s_tuser == REQ_NOT_FOUND)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // consume the entry read last cycle
                if (hit && type_reg == REQ_ARP)
                begin
                    similar_next = 1'b1;
                    if (entry.sender_ip == sip_reg)
                    begin
                        dup_next = 1'b1;
                    end
                end
                if (hit && type_reg == REQ_NOT_FOUND)
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                end
                if (take && !stall)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    hold_next       = '{kind: KIND_REPLY, src_mac: rmac_reg, src_ip: tip_reg,
                                        dst_mac: entry.sender_mac, dst_ip: entry.sender_ip,
                                        lookup_ip: 32'd0};
                    hold_valid_next = 1'b1;
                    valid_next[rd_idx_reg] = 1'b0;
                    served_next     = served_reg + SRV_W'(1);
                end

                // advance the read sweep
                if (!stall)
                begin
                    if (rd_addr_reg < CNT_W'(PENDING_DEPTH))
                    begin
                        ram_rd_en    = 1'b1;
                        rd_pend_next = 1'b1;
                        rd_idx_next  = rd_addr_reg[IDX_W-1:0];
                        rd_addr_next = rd_addr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                    end
                end

                // sweep done once the last entry has been consumed
                if (rd_addr_reg == CNT_W'(PENDING_DEPTH) && !rd_pend_reg)
                begin
                    if (type_reg == REQ_ARP)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (hold_valid_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FINISH:
            begin
                if (dup_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!free_found)
                begin
                    hold_next       = '{kind: KIND_DROP, src_mac: 48'd0, src_ip: 32'd0,
                                        dst_mac: 48'd0, dst_ip: 32'd0, lookup_ip: 32'd0};
                    hold_valid_next = 1'b1;
                    state_next      = ST_FLUSH;
                end
                else
                begin
                    ram_wr_en            = 1'b1;
                    valid_next[free_idx] = 1'b1;
                    if (similar_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        hold_next       = '{kind: KIND_LOOKUP, src_mac: 48'd0, src_ip: 32'd0,
                                            dst_mac: 48'd0, dst_ip: 32'd0, lookup_ip: tip_reg};
                        hold_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                // push the held result as the item's last beat
                if (out_free)
                begin
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            valid_reg         <= '0;
            rd_addr_reg       <= '0;
            rd_pend_reg       <= 1'b0;
            hold_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            router_ip_reg     <= '0;
            router_mac_reg    <= '0;
            subnet_prefix_reg <= '0;
            subnet_mask_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            rd_addr_reg    <= rd_addr_next;
            rd_pend_reg    <= rd_pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ROUTER_IP:     router_ip_reg     <= cfg_data[31:0];
                    CFG_ROUTER_MAC:    router_mac_reg    <= cfg_data;
                    CFG_SUBNET_PREFIX: subnet_prefix_reg <= cfg_data[31:0];
                    CFG_SUBNET_MASK:   subnet_mask_reg   <= cfg_data[31:0];
                    default:           router_ip_reg     <= router_ip_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        smac_reg     <= smac_next;
        sip_reg      <= sip_next;
        tip_reg      <= tip_next;
        rmac_reg     <= rmac_next;
        rd_idx_reg   <= rd_idx_next;
        similar_reg  <= similar_next;
        dup_reg      <= dup_next;
        served_reg   <= served_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // drive the result stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_reg.lookup_ip, out_reg.dst_ip, out_reg.dst_mac,
                       out_reg.src_ip, out_reg.src_mac};

endmodule

/* design/appr_ram.sv */
module appr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
